>>> rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    // Width of one stored key
    localparam int KEY_W = 32;

    // Command codes carried in the request
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Request payload
    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
    } in_t;

    // Result payload
    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] min_key;
        logic [7:0]              count;
    } out_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
    } op_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic                    moves;
    } link_t;

endpackage

>>> rtl/core/min_heap_priority_queue.sv
// Priority queue of signed 32-bit keys that always reports its smallest key.
// Request channel (s_valid, s_ready, s_req): s_req.cmd selects insert of
// s_req.key or removal of the smallest key. Result channel (m_valid, m_ready,
// m_result): one result per request with status (done, insert refused because
// full, removal refused because empty), the smallest key after the operation
// (0 when empty) and the low 8 bits of the key count.
// Keys sit in a sorted row of CAPACITY cells; every cell compares the
// incoming key with its own in the same cycle and shifts right on insert or
// left on removal.
// A request is applied to the row and held pending in pend_reg, then its
// result is registered into out_reg once the output slot is free. No new
// request is taken while one is pending; a result held by the receiver
// blocks the next request after one more has been taken into the row.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; the queue is ready right after reset, no clearing pass is needed.
module min_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mhpq_pkg::in_t  s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output mhpq_pkg::out_t m_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    mhpq_pkg::link_t   links [CAPACITY];
    mhpq_pkg::op_t     op;
    logic              accept;
    logic              full;
    logic              empty;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pend_reg;
    logic              pend_next;
    mhpq_pkg::status_t status_reg;
    mhpq_pkg::status_t status_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    mhpq_pkg::out_t    out_reg;
    mhpq_pkg::out_t    out_next;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign s_ready = !pend_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_result = out_reg;

    // Broadcast the operation, dropping refused ones
    always_comb begin
        op.key = s_req.key;
        op.ins = accept && (s_req.cmd == mhpq_pkg::CMD_INSERT) && !full;
        op.rem = accept && (s_req.cmd == mhpq_pkg::CMD_REMOVE) && !empty;
    end

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        mhpq_pkg::link_t left_link;
        mhpq_pkg::link_t right_link;

        if (i == 0) begin : g_head
            assign left_link = '0;
        end else begin : g_body
            assign left_link = links[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_link = '0;
        end else begin : g_inner
            assign right_link = links[i+1];
        end

        mhpq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (op),
            .left_in  (left_link),
            .right_in (right_link),
            .link_out (links[i])
        );
    end

    // Track count, hold status until the row has settled, then register result
    always_comb begin
        count_next     = count_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (pend_reg && (!out_valid_reg || m_ready)) begin
            pend_next        = 1'b0;
            out_valid_next   = 1'b1;
            out_next.status  = status_reg;
            out_next.min_key = empty ? '0 : links[0].key;
            out_next.count   = 8'(count_reg);
        end

        if (accept) begin
            pend_next = 1'b1;
            unique case (s_req.cmd)
                mhpq_pkg::CMD_INSERT: begin
                    if (full) begin
                        status_next = mhpq_pkg::ST_FULL;
                    end else begin
                        status_next = mhpq_pkg::ST_DONE;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                mhpq_pkg::CMD_REMOVE: begin
                    if (empty) begin
                        status_next = mhpq_pkg::ST_EMPTY;
                    end else begin
                        status_next = mhpq_pkg::ST_DONE;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default: status_next = mhpq_pkg::ST_DONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        out_reg    <= out_next;
    end

endmodule

>>> rtl/core/mhpq_cell.sv
module mhpq_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  mhpq_pkg::op_t   op,
    input  mhpq_pkg::link_t left_in,
    input  mhpq_pkg::link_t right_in,
    output mhpq_pkg::link_t link_out
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [mhpq_pkg::KEY_W-1:0] key_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_next;
    logic                              moves;

    // An empty cell or a larger key yields its place to the new key
    assign moves = !valid_reg || (op.key < key_reg);

    assign link_out.valid = valid_reg;
    assign link_out.key   = key_reg;
    assign link_out.moves = moves;

    // Insert shifts the tail right; remove shifts everything left
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (op.ins && moves) begin
            if (left_in.moves) begin
                valid_next = left_in.valid;
                key_next   = left_in.key;
            end else begin
                valid_next = 1'b1;
                key_next   = op.key;
            end
        end else if (op.rem) begin
            valid_next = right_in.valid;
            key_next   = right_in.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

>>> test/min_heap_priority_queue_tb.sv
module min_heap_priority_queue_tb;

    localparam int CAPACITY = 128;
    localparam int RANDOM_ITEMS = 1800;
    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // One request waiting to be sent; settle holds it until all results are in
    typedef struct {
        mhpq_pkg::in_t req;
        bit            settle;
    } queued_req_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_valid  = 1'b0;
    logic           s_ready;
    mhpq_pkg::in_t  s_req    = '0;
    logic           m_valid;
    logic           m_ready  = 1'b0;
    mhpq_pkg::out_t m_result;

    queued_req_t    queued_requests[$];
    mhpq_pkg::out_t predicted_results[$];

    // Predictor state: array-ordered binary heap
    logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [CAPACITY];
    int heap_len = 0;

    int  mismatch_count = 0;
    int  request_total = 0;
    int  accepted_total = 0;
    logic req_taken = 1'b0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  sink_stall = 0;
    int  sink_calm = 0;
    queued_req_t next_req;
    mhpq_pkg::out_t want;

    min_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void swap_keys(int a, int b);
        logic signed [mhpq_pkg::KEY_W-1:0] tmp;
        tmp = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    // Apply one request to the predicted heap and return the result it yields
    function automatic mhpq_pkg::out_t apply_heap_op(mhpq_pkg::in_t req);
        mhpq_pkg::out_t res;
        int pos;
        int up;
        int best;
        int lc;
        int rc;
        res.status = mhpq_pkg::ST_DONE;
        if (req.cmd == mhpq_pkg::CMD_INSERT) begin
            if (heap_len >= CAPACITY) begin
                res.status = mhpq_pkg::ST_FULL;
            end else begin
                heap_keys[heap_len] = req.key;
                pos = heap_len;
                heap_len++;
                // sift up while the parent is strictly greater
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] <= heap_keys[pos]) break;
                    swap_keys(up, pos);
                    pos = up;
                end
            end
        end else begin
            if (heap_len == 0) begin
                res.status = mhpq_pkg::ST_EMPTY;
            end else begin
                heap_keys[0] = heap_keys[heap_len - 1];
                heap_len--;
                pos = 0;
                // sift down toward the smaller child, left wins a tie
                while (1) begin
                    best = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < heap_len && heap_keys[lc] < heap_keys[best]) best = lc;
                    if (rc < heap_len && heap_keys[rc] < heap_keys[best]) best = rc;
                    if (best == pos) break;
                    swap_keys(best, pos);
                    pos = best;
                end
            end
        end
        res.min_key = (heap_len != 0) ? heap_keys[0] : '0;
        res.count = 8'(heap_len);
        return res;
    endfunction

    // Idle length: mostly short, a few long, with stretches of none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        // narrow range to get plenty of equal keys
        if (r < 3) return $signed(32'($urandom_range(0, 8))) - 4;
        return $urandom;
    endfunction

    function automatic void add_request(logic cmd, logic signed [mhpq_pkg::KEY_W-1:0] key,
                                        bit settle);
        queued_req_t q;
        q.req.cmd = cmd;
        q.req.key = key;
        q.settle = settle;
        queued_requests.push_back(q);
        request_total++;
    endfunction

    // Drive requests at the falling edge; hold until accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold the request
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            s_req <= mhpq_pkg::in_t'({1'($urandom), $urandom});
            send_gap--;
        end else if (queued_requests.size() == 0 ||
                     (queued_requests[0].settle && predicted_results.size() != 0)) begin
            s_valid <= 1'b0;
        end else begin
            next_req = queued_requests.pop_front();
            s_req <= next_req.req;
            s_valid <= 1'b1;
            send_gap = pick_idle(send_calm);
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            m_ready <= 1'b1;
            sink_stall = pick_idle(sink_calm);
        end
    end

    // Check results first, then record the request taken at this edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_results.size() == 0) begin
                report_mismatch($sformatf("result with none pending: status %0d min %0d count %0d",
                                          m_result.status, m_result.min_key, m_result.count));
            end else begin
                want = predicted_results.pop_front();
                if (m_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              m_result.status, want.status));
                if (m_result.min_key !== want.min_key)
                    report_mismatch($sformatf("min_key %0d, predicted %0d",
                                              m_result.min_key, want.min_key));
                if (m_result.count !== want.count)
                    report_mismatch($sformatf("count %0d, predicted %0d",
                                              m_result.count, want.count));
            end
        end
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predicted_results.push_back(apply_heap_op(s_req));
            accepted_total++;
        end
    end

    initial begin
        int n_random;
        int kind;
        int len;
        int ins_pct;
        int wait_cycles;
        bit settle;

        // Directed: empty removal, key extremes, ties, drain past empty
        add_request(mhpq_pkg::CMD_REMOVE, '0, 1'b0);
        add_request(mhpq_pkg::CMD_REMOVE, -1, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, '0, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, KEY_MAX, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, KEY_MIN, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, -1, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, 1, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, 5, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, 5, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, KEY_MIN + 1, 1'b0);
        add_request(mhpq_pkg::CMD_INSERT, KEY_MAX - 1, 1'b0);
        for (int i = 0; i < 10; i++) add_request(mhpq_pkg::CMD_REMOVE, $urandom, 1'b0);
        add_request(mhpq_pkg::CMD_REMOVE, KEY_MAX, 1'b0);

        // Fill past full and drain past empty once for sure
        for (int i = 0; i < CAPACITY + 12; i++)
            add_request(mhpq_pkg::CMD_INSERT, pick_key(), i == 0);
        for (int i = 0; i < CAPACITY + 12; i++)
            add_request(mhpq_pkg::CMD_REMOVE, $urandom, 1'b0);
        n_random = 2 * (CAPACITY + 12);

        // Random phases: insert-heavy, remove-heavy and balanced
        while (n_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 2);
            case (kind)
                0: begin ins_pct = 85; len = $urandom_range(150, 250); end
                1: begin ins_pct = 15; len = $urandom_range(150, 250); end
                default: begin ins_pct = 50; len = $urandom_range(50, 150); end
            endcase
            settle = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                add_request(($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::CMD_INSERT
                                                              : mhpq_pkg::CMD_REMOVE,
                            pick_key(), settle && i == 0);
            end
            n_random += len;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for every request to be taken, then for the results
        while (accepted_total < request_total) @(negedge aclk);
        wait_cycles = 0;
        while (predicted_results.size() != 0 && wait_cycles < 5000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        if (predicted_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
        repeat (10) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
